// File: rtl/tcw_pkg.sv
// Shared types, codes and constants of the text console writer.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

   // Screen geometry defaults
   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;

   // Field widths of the request and response channels
   localparam int CMD_W      = 2;
   localparam int CHAR_W     = 8;
   localparam int COLOR_W    = 4;
   localparam int INDEX_W    = 11;
   localparam int CURSOR_W   = 15;
   localparam int COL_OUT_W  = 7;
   localparam int ROW_OUT_W  = 5;
   localparam int CELL_W     = CHAR_W + COLOR_W;

   // Request queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Character and attribute codes
   localparam logic [CURSOR_W-1:0] HIDDEN_CODE  = 15'd20655;
   localparam logic [CHAR_W-1:0]   SPACE_CODE   = 8'h20;
   localparam logic [CHAR_W-1:0]   NEWLINE_CODE = 8'd10;
   localparam logic [COLOR_W-1:0]  WHITE_COLOR  = 4'hf;

   // Command codes on req_cmd
   localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

   typedef enum logic [1:0] {
      OP_PUT,
      OP_CLEAR,
      OP_READ,
      OP_NOP
   } op_type;

   // One classified request as it waits in the queue
   typedef struct packed {
      op_type               op;
      logic                 newline;
      logic                 in_range;
      logic [CHAR_W-1:0]    char_code;
      logic [COLOR_W-1:0]   color;
      logic [INDEX_W-1:0]   cell_index;
   } entry_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ_WAIT,
      ST_SCROLL_COPY,
      ST_SCROLL_BLANK,
      ST_PUT_LAST,
      ST_CLEAR,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

// File: rtl/text_console_writer.sv
// A put is popped from the queue and written to the screen RAM, while the queue keeps
// taking requests. A read waits for the registered screen RAM read; command 3 goes
// straight to the response. A put that scrolls first copies the rows up through the
// single RAM port pair and blanks the bottom row; a clear writes one cell per cycle.
// Reset (synchronous, active high) starts a pass over ROWS*COLUMNS cells (2000 at 80x25)
// that blanks the screen to spaces in colour 15; req_ready stays low until it ends.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer import tcw_pkg::*; #(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [CMD_W-1:0]     req_cmd,
   input  wire logic [CHAR_W-1:0]    req_char_code,
   input  wire logic [COLOR_W-1:0]   req_color,
   input  wire logic [INDEX_W-1:0]   req_cell_index,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic      [CURSOR_W-1:0]  rsp_cursor_location,
   output logic      [COL_OUT_W-1:0] rsp_cursor_col,
   output logic      [ROW_OUT_W-1:0] rsp_cursor_row,
   output logic                      rsp_scrolled,
   output logic      [CHAR_W-1:0]    rsp_read_char,
   output logic      [COLOR_W-1:0]   rsp_read_color
);

   logic      fill_done;
   logic      q_valid;
   logic      q_pop;
   entry_type q_head;

   tcw_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .fill_done      (fill_done),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_char_code  (req_char_code),
      .req_color      (req_color),
      .req_cell_index (req_cell_index),
      .q_valid        (q_valid),
      .q_head         (q_head),
      .q_pop          (q_pop)
   );

   tcw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .fill_done           (fill_done),
      .q_valid             (q_valid),
      .q_head              (q_head),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_cursor_location (rsp_cursor_location),
      .rsp_cursor_col      (rsp_cursor_col),
      .rsp_cursor_row      (rsp_cursor_row),
      .rsp_scrolled        (rsp_scrolled),
      .rsp_read_char       (rsp_read_char),
      .rsp_read_color      (rsp_read_color)
   );

endmodule

`default_nettype wire

// File: rtl/tcw_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram import tcw_pkg::*; #(
   parameter int WIDTH = CELL_W,
   parameter int DEPTH = DEF_COLUMNS * DEF_ROWS
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: rtl/tcw_front.sv
// Request intake: classifies each request and holds it in a short queue.
`timescale 1ns / 1ps
`default_nettype none

module tcw_front import tcw_pkg::*; #(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               fill_done,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [CMD_W-1:0]   req_cmd,
   input  wire logic [CHAR_W-1:0]  req_char_code,
   input  wire logic [COLOR_W-1:0] req_color,
   input  wire logic [INDEX_W-1:0] req_cell_index,
   output logic                    q_valid,
   output entry_type               q_head,
   input  wire logic               q_pop
);

   localparam int CELLS = ROWS * COLUMNS;

   entry_type            entries_ff [QUEUE_DEPTH];
   entry_type            new_entry;
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]    count_ff, count_in;
   logic                 push;

   always_comb begin
      new_entry.newline    = (req_char_code == NEWLINE_CODE);
      new_entry.in_range   = (32'(req_cell_index) < 32'(CELLS));
      new_entry.char_code  = req_char_code;
      new_entry.color      = req_color;
      new_entry.cell_index = req_cell_index;
      unique case (req_cmd)
         CMD_PUT:   new_entry.op = OP_PUT;
         CMD_CLEAR: new_entry.op = OP_CLEAR;
         CMD_READ:  new_entry.op = OP_READ;
         CMD_NOP:   new_entry.op = OP_NOP;
      endcase
   end

   assign req_ready = fill_done && (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_head    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (q_pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= new_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("request queue count exceeds depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty request queue");

endmodule

`default_nettype wire

// File: rtl/tcw_back.sv
// Execution sequencer: screen store updates, scroll and clear sweeps, response register.
`timescale 1ns / 1ps
`default_nettype none

module tcw_back import tcw_pkg::*; #(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   output logic                        fill_done,
   input  wire logic                   q_valid,
   input  wire entry_type              q_head,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic     [CURSOR_W-1:0]     rsp_cursor_location,
   output logic     [COL_OUT_W-1:0]    rsp_cursor_col,
   output logic     [ROW_OUT_W-1:0]    rsp_cursor_row,
   output logic                        rsp_scrolled,
   output logic     [CHAR_W-1:0]       rsp_read_char,
   output logic     [COLOR_W-1:0]      rsp_read_color
);

   localparam int CELLS   = ROWS * COLUMNS;
   localparam int CELL_AW = $clog2(CELLS);
   localparam int COL_W   = $clog2(COLUMNS + 1);
   localparam int ROW_W   = $clog2(ROWS);
   localparam int ROWC_W  = ROW_W + 1;
   localparam logic [CELL_AW-1:0] LAST_CELL     = CELL_AW'(CELLS - 1);
   localparam logic [CELL_AW-1:0] LAST_ROW_BASE = CELL_AW'(CELLS - COLUMNS);
   localparam logic               CELLS_ODD     = 1'((CELLS - 1) % 2);

   state_type            state_ff, state_in;
   logic [CELL_AW-1:0]   cnt_ff, cnt_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic                 blink_ff, blink_in;
   logic [CURSOR_W-1:0]  cursor_ff, cursor_in;
   logic                 scrolled_ff, scrolled_in;
   logic [CHAR_W-1:0]    rd_char_ff, rd_char_in;
   logic [COLOR_W-1:0]   rd_color_ff, rd_color_in;
   logic [CHAR_W-1:0]    pend_char_ff, pend_char_in;
   logic [COLOR_W-1:0]   pend_color_ff, pend_color_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CURSOR_W-1:0]  rsp_cursor_ff;
   logic [COL_OUT_W-1:0] rsp_col_ff;
   logic [ROW_OUT_W-1:0] rsp_row_ff;
   logic                 rsp_scrolled_ff;
   logic [CHAR_W-1:0]    rsp_char_ff;
   logic [COLOR_W-1:0]   rsp_color_ff;
   logic                 rsp_load;

   logic                 wr_en, rd_en;
   logic [CELL_AW-1:0]   wr_addr, rd_addr;
   logic [CELL_W-1:0]    wr_data, rd_data;

   logic                 moved, need_scroll, last_bit;
   logic [ROWC_W-1:0]    row_inc;
   logic [ROW_W-1:0]     put_row;
   logic [COL_W-1:0]     put_col;
   logic [CELL_AW-1:0]   put_addr;

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Cursor advance for a put at the head of the queue
   always_comb begin
      moved       = (col_ff >= COL_W'(COLUMNS)) || q_head.newline;
      row_inc     = {1'b0, row_ff} + ROWC_W'(1);
      need_scroll = moved && (row_inc == ROWC_W'(ROWS));
      put_row     = moved ? row_inc[ROW_W-1:0] : row_ff;
      put_col     = moved ? '0 : col_ff;
      put_addr    = CELL_AW'(put_row) * CELL_AW'(COLUMNS) + CELL_AW'(put_col);
      last_bit    = blink_ff ^ CELLS_ODD;
   end

   assign fill_done = (state_ff != ST_INIT);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      blink_in      = blink_ff;
      cursor_in     = cursor_ff;
      scrolled_in   = scrolled_ff;
      rd_char_in    = rd_char_ff;
      rd_color_in   = rd_color_ff;
      pend_char_in  = pend_char_ff;
      pend_color_in = pend_color_ff;
      q_pop         = 1'b0;
      rsp_load      = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = cnt_ff;
      wr_data       = {WHITE_COLOR, SPACE_CODE};
      rd_en         = 1'b0;
      rd_addr       = CELL_AW'(q_head.cell_index);

      unique case (state_ff)
         ST_INIT: begin
            wr_en = 1'b1;
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + CELL_AW'(1);
            end
         end

         ST_IDLE: begin
            if (q_valid) begin
               q_pop       = 1'b1;
               scrolled_in = 1'b0;
               rd_char_in  = '0;
               rd_color_in = '0;
               unique case (q_head.op)
                  OP_PUT: begin
                     if (need_scroll) begin
                        // park the character until the screen has moved up
                        pend_char_in  = q_head.char_code;
                        pend_color_in = q_head.color;
                        row_in        = ROW_W'(ROWS - 1);
                        col_in        = '0;
                        scrolled_in   = 1'b1;
                        cnt_in        = '0;
                        state_in      = ST_SCROLL_COPY;
                     end else begin
                        wr_en     = 1'b1;
                        wr_addr   = put_addr;
                        wr_data   = {q_head.color, q_head.char_code};
                        row_in    = put_row;
                        col_in    = put_col + COL_W'(1);
                        blink_in  = ~blink_ff;
                        cursor_in = blink_ff ? HIDDEN_CODE
                                             : CURSOR_W'(put_addr) + CURSOR_W'(1);
                        state_in  = ST_RESP;
                     end
                  end
                  OP_CLEAR: begin
                     cnt_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  OP_READ: begin
                     if (q_head.in_range) begin
                        rd_en    = 1'b1;
                        state_in = ST_READ_WAIT;
                     end else begin
                        state_in = ST_RESP;
                     end
                  end
                  OP_NOP: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         ST_READ_WAIT: begin
            rd_char_in  = rd_data[CHAR_W-1:0];
            rd_color_in = rd_data[CELL_W-1:CHAR_W];
            state_in    = ST_RESP;
         end

         ST_SCROLL_COPY: begin
            // read one row ahead, write back the cell read last cycle
            rd_addr = cnt_ff + CELL_AW'(COLUMNS);
            rd_en   = (cnt_ff != LAST_ROW_BASE);
            wr_en   = (cnt_ff != '0);
            wr_addr = cnt_ff - CELL_AW'(1);
            wr_data = rd_data;
            if (cnt_ff == LAST_ROW_BASE) begin
               state_in = ST_SCROLL_BLANK;
            end else begin
               cnt_in = cnt_ff + CELL_AW'(1);
            end
         end

         ST_SCROLL_BLANK: begin
            wr_en   = 1'b1;
            wr_data = {pend_color_ff, SPACE_CODE};
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = '0;
               state_in = ST_PUT_LAST;
            end else begin
               cnt_in = cnt_ff + CELL_AW'(1);
            end
         end

         ST_PUT_LAST: begin
            wr_en     = 1'b1;
            wr_addr   = LAST_ROW_BASE;
            wr_data   = {pend_color_ff, pend_char_ff};
            col_in    = COL_W'(1);
            blink_in  = ~blink_ff;
            cursor_in = blink_ff ? HIDDEN_CODE
                                 : CURSOR_W'(LAST_ROW_BASE) + CURSOR_W'(1);
            state_in  = ST_RESP;
         end

         ST_CLEAR: begin
            wr_en = 1'b1;
            if (cnt_ff == LAST_CELL) begin
               cnt_in    = '0;
               col_in    = '0;
               row_in    = '0;
               blink_in  = ~last_bit;
               cursor_in = last_bit ? HIDDEN_CODE : CURSOR_W'(CELLS);
               state_in  = ST_RESP;
            end else begin
               cnt_in = cnt_ff + CELL_AW'(1);
            end
         end

         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         blink_ff     <= 1'b0;
         cursor_ff    <= '0;
         scrolled_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         blink_ff     <= blink_in;
         cursor_ff    <= cursor_in;
         scrolled_ff  <= scrolled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_char_ff    <= rd_char_in;
      rd_color_ff   <= rd_color_in;
      pend_char_ff  <= pend_char_in;
      pend_color_ff <= pend_color_in;
      if (rsp_load) begin
         rsp_cursor_ff   <= cursor_ff;
         rsp_col_ff      <= COL_OUT_W'(col_ff);
         rsp_row_ff      <= ROW_OUT_W'(row_ff);
         rsp_scrolled_ff <= scrolled_ff;
         rsp_char_ff     <= rd_char_ff;
         rsp_color_ff    <= rd_color_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_location = rsp_cursor_ff;
   assign rsp_cursor_col      = rsp_col_ff;
   assign rsp_cursor_row      = rsp_row_ff;
   assign rsp_scrolled        = rsp_scrolled_ff;
   assign rsp_read_char       = rsp_char_ff;
   assign rsp_read_color      = rsp_color_ff;

   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (32'(wr_addr) < 32'(CELLS)))
      else $error("screen write beyond last cell");

   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      (32'(row_ff) < 32'(ROWS)) && (32'(col_ff) <= 32'(COLUMNS)))
      else $error("cursor outside the screen");

   a_put_after_scroll: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUT_LAST) |-> ($past(state_ff) == ST_SCROLL_BLANK))
      else $error("deferred put without a completed scroll");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff)
      else $error("loaded response not presented");

endmodule

`default_nettype wire

// File: test/tb_text_console_writer.sv
// Self-checking testbench for the text console writer: screen model, driver and checker.
`timescale 1ns / 1ps

module tb_text_console_writer;
   import tcw_pkg::*;

   localparam int COLUMNS      = DEF_COLUMNS;
   localparam int ROWS         = DEF_ROWS;
   localparam int CELLS        = COLUMNS * ROWS;
   localparam int RANDOM_ITEMS = 400;
   localparam int TAIL_ITEMS   = 40;
   localparam int DRAIN_CYCLES = CELLS + 200;
   localparam int LIMIT_CYCLES = 5_000_000;
   localparam int MAX_REPORTS  = 10;

   typedef struct {
      logic [CMD_W-1:0]   cmd;
      logic [CHAR_W-1:0]  char_code;
      logic [COLOR_W-1:0] color;
      logic [INDEX_W-1:0] cell_index;
      bit                 wait_drained;
   } console_req_type;

   typedef struct packed {
      logic [CURSOR_W-1:0]  cursor_location;
      logic [COL_OUT_W-1:0] cursor_col;
      logic [ROW_OUT_W-1:0] cursor_row;
      logic                 scrolled;
      logic [CHAR_W-1:0]    read_char;
      logic [COLOR_W-1:0]   read_color;
   } console_rsp_type;

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_ready;
   logic [CMD_W-1:0]     req_cmd        = CMD_NOP;
   logic [CHAR_W-1:0]    req_char_code  = '0;
   logic [COLOR_W-1:0]   req_color      = '0;
   logic [INDEX_W-1:0]   req_cell_index = '0;
   logic                 rsp_valid;
   logic                 rsp_ready      = 1'b0;
   logic [CURSOR_W-1:0]  rsp_cursor_location;
   logic [COL_OUT_W-1:0] rsp_cursor_col;
   logic [ROW_OUT_W-1:0] rsp_cursor_row;
   logic                 rsp_scrolled;
   logic [CHAR_W-1:0]    rsp_read_char;
   logic [COLOR_W-1:0]   rsp_read_color;

   text_console_writer u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cmd             (req_cmd),
      .req_char_code       (req_char_code),
      .req_color           (req_color),
      .req_cell_index      (req_cell_index),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_cursor_location (rsp_cursor_location),
      .rsp_cursor_col      (rsp_cursor_col),
      .rsp_cursor_row      (rsp_cursor_row),
      .rsp_scrolled        (rsp_scrolled),
      .rsp_read_char       (rsp_read_char),
      .rsp_read_color      (rsp_read_color)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Screen model state
   logic [CELL_W-1:0]   screen_model [CELLS];
   int                  model_col;
   int                  model_row;
   logic                model_blink;
   logic [CURSOR_W-1:0] model_cursor;

   console_req_type pending_requests [$];
   console_rsp_type expected_replies [$];
   console_req_type active_request;
   int              accepted_count = 0;
   int              total_requests = 0;
   int              mismatch_count = 0;
   int              cycle_count    = 0;
   int              req_gap        = 0;
   int              rsp_stall      = 0;
   bit              quiet_tail     = 1'b0;

   task automatic blank_screen_model(input logic [COLOR_W-1:0] fill_color);
      for (int i = 0; i < CELLS; i++)
         screen_model[i] = {fill_color, SPACE_CODE};
   endtask

   task automatic apply_to_screen_model(input console_req_type rq,
                                        output console_rsp_type rs);
      logic last_bit;
      rs = '0;
      case (rq.cmd)
         CMD_PUT: begin
            if (model_col >= COLUMNS || rq.char_code == NEWLINE_CODE) begin
               model_row++;
               model_col = 0;
            end
            // scroll ahead of the write
            if (model_row >= ROWS) begin
               for (int i = 0; i < CELLS; i++)
                  screen_model[i] = (i + COLUMNS < CELLS) ? screen_model[i + COLUMNS]
                                                          : {rq.color, SPACE_CODE};
               model_row = ROWS - 1;
               rs.scrolled = 1'b1;
            end
            screen_model[model_row * COLUMNS + model_col] = {rq.color, rq.char_code};
            model_col++;
            if (!model_blink) begin
               model_cursor = CURSOR_W'(model_row * COLUMNS + model_col);
               model_blink  = 1'b1;
            end else begin
               model_cursor = HIDDEN_CODE;
               model_blink  = 1'b0;
            end
         end
         CMD_CLEAR: begin
            // blink comes out as if it toggled once per cell of the fill
            last_bit = model_blink ^ 1'((CELLS - 1) & 1);
            blank_screen_model(WHITE_COLOR);
            model_cursor = last_bit ? HIDDEN_CODE : CURSOR_W'((ROWS - 1) * COLUMNS + COLUMNS);
            model_blink  = ~last_bit;
            model_col    = 0;
            model_row    = 0;
         end
         CMD_READ: begin
            if (rq.cell_index < CELLS)
               {rs.read_color, rs.read_char} = screen_model[rq.cell_index];
         end
         default: ;
      endcase
      rs.cursor_location = model_cursor;
      rs.cursor_col      = COL_OUT_W'(model_col);
      rs.cursor_row      = ROW_OUT_W'(model_row);
   endtask

   function automatic console_req_type make_request(input logic [CMD_W-1:0] cmd,
                                                    input logic [CHAR_W-1:0] ch,
                                                    input logic [COLOR_W-1:0] color,
                                                    input logic [INDEX_W-1:0] index);
      console_req_type rq;
      rq.cmd          = cmd;
      rq.char_code    = ch;
      rq.color        = color;
      rq.cell_index   = index;
      rq.wait_drained = 1'b0;
      return rq;
   endfunction

   // Request driver
   always @(posedge clock) begin
      logic next_valid;
      console_rsp_type reply;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         if (req_valid && req_ready) begin
            apply_to_screen_model(active_request, reply);
            expected_replies.push_back(reply);
            accepted_count++;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_requests.size() > 0 &&
                         (!pending_requests[0].wait_drained ||
                          expected_replies.size() == 0)) begin
               if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                  req_gap = $urandom_range(1, 5) - 1;
               end else begin
                  active_request = pending_requests.pop_front();
                  req_cmd        <= active_request.cmd;
                  req_char_code  <= active_request.char_code;
                  req_color      <= active_request.color;
                  req_cell_index <= active_request.cell_index;
                  next_valid     = 1'b1;
               end
            end
         end
         req_valid  <= next_valid;
         quiet_tail <= (pending_requests.size() < TAIL_ITEMS);
      end
   end

   // Response checker
   always @(posedge clock) begin
      console_rsp_type got;
      console_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_cursor_location, rsp_cursor_col, rsp_cursor_row,
                   rsp_scrolled, rsp_read_char, rsp_read_color};
            if (expected_replies.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("unexpected response: loc %0d col %0d row %0d", got.cursor_location,
                           got.cursor_col, got.cursor_row);
            end else begin
               want = expected_replies.pop_front();
               if (got.cursor_location !== want.cursor_location ||
                   got.cursor_col !== want.cursor_col || got.cursor_row !== want.cursor_row ||
                   got.scrolled !== want.scrolled || got.read_char !== want.read_char ||
                   got.read_color !== want.read_color) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("mismatch: exp loc %0d col %0d row %0d scr %0b ch %0h clr %0h | ",
                              want.cursor_location, want.cursor_col, want.cursor_row,
                              want.scrolled, want.read_char, want.read_color,
                              "got loc %0d col %0d row %0d scr %0b ch %0h clr %0h",
                              got.cursor_location, got.cursor_col, got.cursor_row,
                              got.scrolled, got.read_char, got.read_color);
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            rsp_stall = $urandom_range(1, 5) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      console_req_type rq;
      int mode;
      int pick;
      model_col    = 0;
      model_row    = 0;
      model_blink  = 1'b0;
      model_cursor = '0;
      blank_screen_model(WHITE_COLOR);

      // directed: reset contents, index extremes, field extremes, newline, clear
      pending_requests.push_back(make_request(CMD_READ, 8'h00, 4'h0, 11'd0));
      pending_requests.push_back(make_request(CMD_READ, 8'hff, 4'hf, 11'd1999));
      pending_requests.push_back(make_request(CMD_READ, 8'h00, 4'h0, 11'd2000));
      pending_requests.push_back(make_request(CMD_READ, 8'hff, 4'hf, 11'h7ff));
      pending_requests.push_back(make_request(CMD_NOP, 8'hff, 4'hf, 11'h7ff));
      pending_requests.push_back(make_request(CMD_PUT, 8'h41, 4'h0, 11'd0));
      pending_requests.push_back(make_request(CMD_PUT, 8'hff, 4'hf, 11'h7ff));
      pending_requests.push_back(make_request(CMD_PUT, 8'h00, 4'h5, 11'd0));
      pending_requests.push_back(make_request(CMD_PUT, NEWLINE_CODE, 4'ha, 11'd0));
      pending_requests.push_back(make_request(CMD_PUT, NEWLINE_CODE, 4'h3, 11'd0));
      pending_requests.push_back(make_request(CMD_PUT, 8'h7e, 4'hc, 11'd0));
      pending_requests.push_back(make_request(CMD_READ, 8'h00, 4'h0, 11'd1));
      pending_requests.push_back(make_request(CMD_READ, 8'h00, 4'h0, 11'd80));
      pending_requests.push_back(make_request(CMD_READ, 8'h00, 4'h0, 11'd160));
      pending_requests.push_back(make_request(CMD_NOP, 8'h00, 4'h0, 11'd0));
      rq = make_request(CMD_CLEAR, 8'h55, 4'h9, 11'h2aa);
      rq.wait_drained = 1'b1;
      pending_requests.push_back(rq);
      pending_requests.push_back(make_request(CMD_READ, 8'h00, 4'h0, 11'd0));
      pending_requests.push_back(make_request(CMD_PUT, 8'h20, 4'h1, 11'd0));
      pending_requests.push_back(make_request(CMD_CLEAR, 8'h00, 4'h0, 11'd0));

      // random: each burst of 50 picks short rows, long wrapping rows or a mix for its puts
      mode = 0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 50 == 0)
            mode = $urandom_range(0, 2);
         rq = make_request(CMD_PUT, CHAR_W'($urandom_range(0, 255)),
                           COLOR_W'($urandom_range(0, 15)), INDEX_W'($urandom_range(0, 2047)));
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            rq.cmd = CMD_PUT;
            case (mode)
               0: if ($urandom_range(0, 2) == 0) rq.char_code = NEWLINE_CODE;
               1: if (rq.char_code == NEWLINE_CODE) rq.char_code = 8'h0b;
               default: if ($urandom_range(0, 15) == 0) rq.char_code = NEWLINE_CODE;
            endcase
         end else if (pick < 74) begin
            rq.cmd = CMD_CLEAR;
         end else if (pick < 93) begin
            rq.cmd = CMD_READ;
            if ($urandom_range(0, 2) == 0)
               rq.cell_index = INDEX_W'($urandom_range((ROWS - 1) * COLUMNS, CELLS - 1));
         end else begin
            rq.cmd = CMD_NOP;
         end
         // hold the sender once mid-run until all responses are back
         if (i == RANDOM_ITEMS / 2)
            rq.wait_drained = 1'b1;
         pending_requests.push_back(rq);
      end
      total_requests = pending_requests.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (accepted_count < total_requests || expected_replies.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && expected_replies.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_front.sv
rtl/tcw_back.sv
rtl/text_console_writer.sv
test/tb_text_console_writer.sv
